### rtl/core/kses_pkg.sv
// Shared types, constants and the key map of the keypad scanner with event queue.
package kses_pkg;

	// Request type codes.
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Default depth of the character store.
	localparam int FIFO_DEPTH_DEF = 256;
	// Most characters one read request may pop.
	localparam int MAX_READ = 32;
	// Width of a pop count, enough to hold MAX_READ.
	localparam int CNT_W = $clog2(MAX_READ + 1);
	// Depth of the small queues between the parts.
	localparam int Q_DEPTH = 2;

	localparam int NUM_ROWS = 4;
	localparam int NUM_COLS = 3;

	// ASCII character of each key, by row and column.
	localparam logic [7:0] KEY_MAP [NUM_ROWS][NUM_COLS] = '{
		'{8'h31, 8'h32, 8'h33},
		'{8'h34, 8'h35, 8'h36},
		'{8'h37, 8'h38, 8'h39},
		'{8'h2A, 8'h30, 8'h23}
	};

	typedef struct packed {
		logic       req_type;
		logic [2:0] column_bits;
		logic [5:0] max_count;
	} in_item_t;

	typedef struct packed {
		logic [3:0] row_drive;
		logic       key_valid;
		logic [7:0] key_code;
		logic       empty_res;
		logic       overflow;
		logic       last;
	} out_item_t;

	// Command handed from the scanner front to the queue engine.
	typedef struct packed {
		logic             is_read;
		logic [3:0]       row_drive;
		logic [1:0]       press_row;
		logic [2:0]       press_mask;
		logic [CNT_W-1:0] count;
	} cmd_t;

endpackage

### rtl/core/keypad_scan_event_fifo_unit.sv
// Top level of the 4x3 keypad scanner with a queue of key characters.
// Overview: each input item is either a scan sample (the three column levels read back
// for the row that row_drive named) or a read request. A scan sample compares the levels
// with the stored ones; every key that goes from released to pressed puts its ASCII
// character ('1'..'9', '*', '0', '#') into a character store of FIFO_DEPTH entries, taken
// in column order, and the driven row then advances. When the store is full the character
// is dropped and the overflow flag is set until reset. Every scan gives one item with
// last set. A read pops up to max_count characters (at most 32), one item each, the final
// one marked by last; with nothing to pop it gives one item, with empty_res set if the
// store is empty. Timing: items enter a two-entry command queue at one per cycle while it
// is not full; the queue engine behind it handles a scan as a dispatch step, one step per
// column on the store's single write port and a reply, and a read as a dispatch step plus
// an address step and a data step per character, set by the registered read of the store.
// Results leave through a two-entry result queue, so the engine keeps working while the
// consumer holds off, until that queue is full. The store needs no clearing after reset:
// only written entries are ever read.
module keypad_scan_event_fifo_unit import kses_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  request,
	output logic      full,
	input  logic      pop,
	output out_item_t result,
	output logic      empty
);

	// Command path between the scanner front and the queue engine.
	logic      cmd_push;
	cmd_t      cmd_in;
	logic      cmd_full;
	logic      cmd_pop;
	cmd_t      cmd_out;
	logic      cmd_empty;

	// Result path from the queue engine to the consumer.
	logic      res_push;
	out_item_t res_in;
	logic      res_full;

	// The block is full whenever the command queue cannot take another item.
	assign full = cmd_full;

	kses_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.request (request),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	kses_queue #(
		.entry_t(cmd_t),
		.DEPTH  (Q_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (cmd_empty)
	);

	kses_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_item (res_in)
	);

	kses_queue #(
		.entry_t(out_item_t),
		.DEPTH  (Q_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

### rtl/core/kses_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kses_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/kses_queue.sv
// Small register queue used between the parts of the keypad scanner.
module kses_queue import kses_pkg::*; #(
	parameter type entry_t = logic,
	parameter int  DEPTH   = Q_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   full,
	input  logic   pop,
	output entry_t dout,
	output logic   empty
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [IW-1:0]   wr_q;
	logic [IW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push_ok;
	logic            pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + IW'(1);
			end
			if (pop_ok) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + IW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

### rtl/core/kses_front.sv
// Scanner front: tracks the driven row and key levels, classifies items into commands.
module kses_front import kses_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t request,
	input  logic     cmd_full,
	output logic     cmd_push,
	output cmd_t     cmd
);

	logic [1:0] row_q;
	logic [2:0] levels_q [NUM_ROWS];
	logic [1:0] row_next;
	logic       scan_ok;

	assign cmd_push = push && !cmd_full;
	assign scan_ok  = cmd_push && (request.req_type == REQ_SCAN);
	assign row_next = row_q + 2'd1;

	always_comb begin
		cmd = '0;
		cmd.press_row = row_q;
		if (request.req_type == REQ_READ) begin
			cmd.is_read   = 1'b1;
			cmd.row_drive = 4'(1) << row_q;
			if (int'(request.max_count) > MAX_READ) begin
				cmd.count = CNT_W'(MAX_READ);
			end else begin
				cmd.count = CNT_W'(request.max_count);
			end
		end else begin
			cmd.is_read    = 1'b0;
			cmd.row_drive  = 4'(1) << row_next;
			// A key enters the queue only on its released-to-pressed change.
			cmd.press_mask = request.column_bits & ~levels_q[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			for (int r = 0; r < NUM_ROWS; r++) begin
				levels_q[r] <= '0;
			end
		end else if (scan_ok) begin
			row_q           <= row_next;
			levels_q[row_q] <= request.column_bits;
		end
	end

endmodule

### rtl/core/kses_back.sv
// Queue engine: writes pressed characters into the store and serves read requests.
module kses_back import kses_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_empty,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	input  logic      out_full,
	output logic      out_push,
	output out_item_t out_item
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PUSH    = 3'd1;
	localparam logic [2:0] ST_REPLY   = 3'd2;
	localparam logic [2:0] ST_RD_ADDR = 3'd3;
	localparam logic [2:0] ST_RD_DATA = 3'd4;

	logic [2:0]       state_q;
	cmd_t             cmd_q;
	logic [1:0]       col_q;
	logic             empty_q;
	logic [CNT_W-1:0] remain_q;
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [FW-1:0]    fill_q;
	logic             overflow_q;

	logic             ram_wr;
	logic             ram_rd;
	logic [7:0]       ram_rdata;
	logic [CNT_W-1:0] pop_n;
	logic             store_full;

	assign store_full = (fill_q == FW'(FIFO_DEPTH));
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty;
	assign ram_wr     = (state_q == ST_PUSH) && cmd_q.press_mask[col_q] && !store_full;
	assign ram_rd     = (state_q == ST_RD_ADDR);
	assign pop_n      = (int'(fill_q) < int'(cmd.count)) ? CNT_W'(fill_q) : cmd.count;

	kses_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(wr_ptr_q),
		.wr_data(KEY_MAP[cmd_q.press_row][col_q]),
		.rd_en  (ram_rd),
		.rd_addr(rd_ptr_q),
		.rd_data(ram_rdata)
	);

	always_comb begin
		out_push = 1'b0;
		out_item = '0;
		out_item.row_drive = cmd_q.row_drive;
		out_item.overflow  = overflow_q;
		case (state_q)
			ST_REPLY: begin
				out_push           = !out_full;
				out_item.empty_res = empty_q;
				out_item.last      = 1'b1;
			end
			ST_RD_DATA: begin
				out_push           = !out_full;
				out_item.key_valid = 1'b1;
				out_item.key_code  = ram_rdata;
				out_item.last      = (remain_q == CNT_W'(1));
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			empty_q    <= 1'b0;
			remain_q   <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						col_q   <= '0;
						empty_q <= (fill_q == '0);
						if (!cmd.is_read) begin
							state_q <= ST_PUSH;
						end else if (fill_q == '0 || cmd.count == '0) begin
							state_q <= ST_REPLY;
						end else begin
							remain_q <= pop_n;
							state_q  <= ST_RD_ADDR;
						end
					end
				end
				ST_PUSH: begin
					if (cmd_q.press_mask[col_q]) begin
						if (store_full) begin
							overflow_q <= 1'b1;
						end else begin
							wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ?
								'0 : wr_ptr_q + AW'(1);
							fill_q   <= fill_q + FW'(1);
						end
					end
					col_q <= col_q + 2'd1;
					if (col_q == 2'(NUM_COLS - 1)) begin
						empty_q <= 1'b0;
						state_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (!out_full) begin
						rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ?
							'0 : rd_ptr_q + AW'(1);
						fill_q   <= fill_q - FW'(1);
						remain_q <= remain_q - CNT_W'(1);
						state_q  <= (remain_q == CNT_W'(1)) ? ST_IDLE : ST_RD_ADDR;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
